### hw/rtl/nsee_pkg.sv
// Shared types and constants of the n-vector spin energy engine.
// Used by the top level and by the port checker; no dependencies.
`default_nettype none

package nsee_pkg;

  localparam int DEF_MAX_SITES      = 4096;
  localparam int DEF_MAX_COMPONENTS = 8;

  localparam int SPIN_W = 16;   // Q2.14 spin component
  localparam int COUP_W = 16;   // Q4.12 coupling
  localparam int ACC_W  = 38;   // Q12.26 field accumulator
  localparam int OUT_W  = 48;   // energy results
  localparam int MAG_W  = 15;   // magnetization result
  localparam int CC_W   = 4;    // component_count register
  localparam int SC_W   = 13;   // site_count register
  localparam int SQ_W   = 64;   // sum of squares
  localparam int ROOT_W = 32;   // integer square root

  localparam logic [CC_W-1:0] CC_RESET = 4'd3;
  localparam logic [SC_W-1:0] SC_RESET = 13'd4096;

  // request codes
  localparam logic [2:0] REQ_WR_SPIN  = 3'd0;
  localparam logic [2:0] REQ_WR_PROP  = 3'd1;
  localparam logic [2:0] REQ_NEIGHBOR = 3'd2;
  localparam logic [2:0] REQ_ACCEPT   = 3'd3;
  localparam logic [2:0] REQ_MAG      = 3'd4;

  // register indexes
  localparam logic REG_COMP_COUNT = 1'b0;
  localparam logic REG_SITE_COUNT = 1'b1;

  // result kinds
  localparam logic RES_ENERGY = 1'b0;
  localparam logic RES_MAG    = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WRAP,
    S_NB_RD,
    S_NB_MUL,
    S_NB_ACC,
    S_EN_RD,
    S_EN_MD,
    S_EN_AD,
    S_EN_AL,
    S_EN_FIN,
    S_AC_WR,
    S_MG_RD,
    S_MG_AD,
    S_MG_SQ,
    S_MG_SA,
    S_SQ_INIT,
    S_SQRT,
    S_DIV,
    S_MG_OUT
  } nsee_state_t;

endpackage

`default_nettype wire

### hw/rtl/nsee_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nsee_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/nvector_spin_energy_engine_top.sv
// Sequencing: an out-of-range site adds wrap steps when MAX_SITES is below 4096;
//   the last neighbour term also runs the energy pass over all components.
// Throughput: one word at a time; the single spin RAM read port and the shared
//   multiplier set the pace.
// Reset: rst_n is synchronous, active low; clears the sequencer, output valid,
//   field accumulators and config registers. Spin RAM and proposal are not cleared.
`default_nettype none

module nvector_spin_energy_engine_top
  import nsee_pkg::*;
#(
  parameter int MAX_SITES      = DEF_MAX_SITES,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          in_req_type,
  input  wire logic [11:0]         in_site,
  input  wire logic [2:0]          in_component,
  input  wire logic signed [15:0]  in_value,
  input  wire logic signed [15:0]  in_coupling,
  input  wire logic [11:0]         in_target_site,
  input  wire logic                in_last,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_result_kind,
  output logic signed [OUT_W-1:0]  out_delta_energy,
  output logic signed [OUT_W-1:0]  out_local_energy,
  output logic [MAG_W-1:0]         out_magnetization,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // Widths that follow from the store geometry.
  localparam int SAW  = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;       // site index
  localparam int CW   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int SRW  = (SAW > 12) ? SAW : 12;                         // latched site
  localparam int SW   = $clog2(MAX_SITES + 1);                         // site count
  localparam int MBW  = SPIN_W + SAW + 1;                              // spin sum / mul B
  localparam int PW   = ACC_W + MBW;                                   // product
  localparam int DW   = ACC_W + SPIN_W + 5;                            // energy sums
  localparam int RAW  = SAW + CW;
  localparam int RDEP = MAX_SITES * (2 ** CW);

  localparam logic signed [DW:0]    RND_HALF = (DW+1)'(32768);
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers. pready is tied high; a write lands on the access
  // cycle. paddr[2] selects the register, the low address bits are ignored.
  // ---------------------------------------------------------------------------
  logic [CC_W-1:0] cc_r;
  logic [SC_W-1:0] sc_r;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= CC_RESET;
      sc_r <= SC_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COMP_COUNT) begin
        cc_r <= pwdata[CC_W-1:0];
      end else begin
        sc_r <= pwdata[SC_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_COMP_COUNT) begin
      prdata = {{(32-CC_W){1'b0}}, cc_r};
    end else begin
      prdata = {{(32-SC_W){1'b0}}, sc_r};
    end
  end

  // Components in use, limited to the store; sites summed, limited to 1..MAX_SITES.
  logic [3:0]    n_comp;
  logic [SW-1:0] n_sites;

  always_comb begin
    n_comp = (cc_r > 4'(MAX_COMPONENTS)) ? 4'(MAX_COMPONENTS) : cc_r;
    if (sc_r == '0) begin
      n_sites = SW'(1);
    end else if (17'(sc_r) > 17'(MAX_SITES)) begin
      n_sites = SW'(MAX_SITES);
    end else begin
      n_sites = SW'(sc_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Latched input word.
  // ---------------------------------------------------------------------------
  nsee_state_t state_r, state_nxt;

  logic [2:0]         req_r;
  logic [SRW-1:0]     site_r;
  logic [SRW-1:0]     tgt_r;
  logic [2:0]         comp_r;
  logic signed [15:0] value_r;
  logic signed [15:0] coup_r;
  logic               last_r;

  logic in_acc;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Sites at or past MAX_SITES wrap by repeated subtraction in S_WRAP.
  logic site_hi, tgt_hi, wrap_done;
  assign site_hi   = 17'(site_r) >= 17'(MAX_SITES);
  assign tgt_hi    = 17'(tgt_r) >= 17'(MAX_SITES);
  assign wrap_done = !site_hi && !tgt_hi;

  // ---------------------------------------------------------------------------
  // Working state.
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0]  acc_r  [MAX_COMPONENTS];
  logic signed [SPIN_W-1:0] prop_r [MAX_COMPONENTS];

  logic [3:0]              j_r;       // component counter
  logic [SW-1:0]           i_r;       // site counter for magnetization
  logic signed [SPIN_W-1:0] s_r;      // target spin component held for second product
  logic signed [DW-1:0]    dsum_r;
  logic signed [DW-1:0]    lsum_r;
  logic signed [MBW-1:0]   ssum_r;
  logic [SQ_W-1:0]         m_r;       // saturating sum of squares
  logic [SQ_W-1:0]         x_r;       // square root remainder
  logic [SQ_W-1:0]         root_r;
  logic [SQ_W-1:0]         bit_r;
  logic [4:0]              it_r;
  logic [ROOT_W-1:0]       dvd_r;     // dividend, becomes the quotient
  logic [SW-1:0]           rem_r;

  logic                    out_valid_r;
  logic                    out_kind_r;
  logic signed [OUT_W-1:0] out_de_r;
  logic signed [OUT_W-1:0] out_le_r;
  logic [MAG_W-1:0]        out_mag_r;

  logic [CW-1:0] jx;
  logic          j_end;      // this pass handles the last component
  logic          comp_ok;
  logic          out_free;

  assign jx       = j_r[CW-1:0];
  assign j_end    = (j_r + 4'd1) == n_comp;
  assign comp_ok  = {1'b0, comp_r} < 4'(MAX_COMPONENTS);
  assign out_free = !out_valid_r || out_ready;

  // ---------------------------------------------------------------------------
  // Spin store: {site, component} addressing, one read and one write port.
  // ---------------------------------------------------------------------------
  logic                     ram_we;
  logic [RAW-1:0]           ram_waddr;
  logic [SPIN_W-1:0]        ram_wdata;
  logic [RAW-1:0]           ram_raddr;
  logic [SPIN_W-1:0]        ram_rdata;
  logic signed [SPIN_W-1:0] spin_rd;

  assign spin_rd = signed'(ram_rdata);

  nsee_ram #(
    .WIDTH (SPIN_W),
    .DEPTH (RDEP)
  ) u_spin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier, registered output. Operands depend on the sequencer step:
  // coupling x spin, accumulator x (spin - proposal), accumulator x spin, or the
  // square of a component's spin sum.
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] mul_a;
  logic signed [MBW-1:0]   mul_b;
  logic signed [PW-1:0]    prod_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_NB_MUL: begin
        mul_a = ACC_W'(coup_r);
        mul_b = MBW'(spin_rd);
      end
      S_EN_MD: begin
        mul_a = acc_r[jx];
        mul_b = MBW'(spin_rd) - MBW'(prop_r[jx]);
      end
      S_EN_AD: begin
        mul_a = acc_r[jx];
        mul_b = MBW'(s_r);
      end
      S_MG_SQ: begin
        mul_a = ACC_W'(ssum_r);
        mul_b = ssum_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------------------
  // Arithmetic helpers.
  // ---------------------------------------------------------------------------
  // Add a product into a field accumulator, saturating at 38 bits.
  function automatic logic signed [ACC_W-1:0] acc_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [PW-1:0]    p
  );
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(p);
    if (s[ACC_W] != s[ACC_W-1]) begin
      acc_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_add = s[ACC_W-1:0];
    end
  endfunction

  // Drop 16 fraction bits, rounding ties upward, then saturate to 48 bits.
  function automatic logic signed [OUT_W-1:0] rnd_sat(input logic signed [DW:0] x);
    logic signed [DW:0] t;
    t = (x + RND_HALF) >>> 16;
    if (t > (DW+1)'(OUT_MAX)) begin
      rnd_sat = OUT_MAX;
    end else if (t < (DW+1)'(OUT_MIN)) begin
      rnd_sat = OUT_MIN;
    end else begin
      rnd_sat = t[OUT_W-1:0];
    end
  endfunction

  logic [SQ_W:0]   sq_sum;
  logic [SQ_W-1:0] sq_add;
  logic [SQ_W-1:0] root_try;
  logic [SW:0]     rem_try;
  logic signed [DW:0] lneg;

  always_comb begin
    sq_add   = SQ_W'(prod_r);
    sq_sum   = {1'b0, m_r} + {1'b0, sq_add};
    root_try = root_r + bit_r;
    rem_try  = {rem_r, dvd_r[ROOT_W-1]};
    lneg     = -(DW+1)'(lsum_r);
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_WRAP;
      end
      S_WRAP: begin
        if (wrap_done) begin
          case (req_r)
            REQ_NEIGHBOR: begin
              if (n_comp != 4'd0) state_nxt = S_NB_RD;
              else state_nxt = last_r ? S_EN_FIN : S_IDLE;
            end
            REQ_ACCEPT: state_nxt = (n_comp != 4'd0) ? S_AC_WR : S_IDLE;
            REQ_MAG:    state_nxt = (n_comp != 4'd0) ? S_MG_RD : S_SQ_INIT;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_NB_RD:  state_nxt = S_NB_MUL;
      S_NB_MUL: state_nxt = S_NB_ACC;
      S_NB_ACC: begin
        if (!j_end) state_nxt = S_NB_RD;
        else state_nxt = last_r ? S_EN_RD : S_IDLE;
      end
      S_EN_RD:  state_nxt = S_EN_MD;
      S_EN_MD:  state_nxt = S_EN_AD;
      S_EN_AD:  state_nxt = S_EN_AL;
      S_EN_AL:  state_nxt = j_end ? S_EN_FIN : S_EN_RD;
      S_EN_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_AC_WR: begin
        if (j_end) state_nxt = S_IDLE;
      end
      S_MG_RD:  state_nxt = S_MG_AD;
      S_MG_AD:  state_nxt = ((i_r + SW'(1)) == n_sites) ? S_MG_SQ : S_MG_RD;
      S_MG_SQ:  state_nxt = S_MG_SA;
      S_MG_SA:  state_nxt = j_end ? S_SQ_INIT : S_MG_RD;
      S_SQ_INIT: state_nxt = S_SQRT;
      S_SQRT: begin
        if (it_r == 5'd31) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (it_r == 5'd31) state_nxt = S_MG_OUT;
      end
      S_MG_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: RAM controls.
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {site_r[SAW-1:0], comp_r[CW-1:0]};
    ram_wdata = value_r;
    ram_raddr = {site_r[SAW-1:0], jx};
    unique case (state_r)
      S_WRAP: begin
        ram_we = wrap_done && (req_r == REQ_WR_SPIN) && comp_ok;
      end
      S_AC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {tgt_r[SAW-1:0], jx};
        ram_wdata = prop_r[jx];
      end
      S_EN_RD: begin
        ram_raddr = {tgt_r[SAW-1:0], jx};
      end
      S_MG_RD: begin
        ram_raddr = {i_r[SAW-1:0], jx};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_EN_FIN || state_r == S_MG_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Field accumulators reset to zero and clear after each energy result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_COMPONENTS; k++) acc_r[k] <= '0;
    end else if (state_r == S_NB_ACC) begin
      acc_r[jx] <= acc_add(acc_r[jx], prod_r);
    end else if (state_r == S_EN_FIN && out_free) begin
      for (int k = 0; k < MAX_COMPONENTS; k++) acc_r[k] <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_r   <= in_req_type;
          site_r  <= SRW'(in_site);
          tgt_r   <= SRW'(in_target_site);
          comp_r  <= in_component;
          value_r <= in_value;
          coup_r  <= in_coupling;
          last_r  <= in_last;
        end
      end
      S_WRAP: begin
        if (site_hi) site_r <= site_r - SRW'(MAX_SITES);
        if (tgt_hi)  tgt_r  <= tgt_r - SRW'(MAX_SITES);
        j_r    <= 4'd0;
        i_r    <= '0;
        dsum_r <= '0;
        lsum_r <= '0;
        ssum_r <= '0;
        m_r    <= '0;
        if (wrap_done && req_r == REQ_WR_PROP && comp_ok) begin
          prop_r[comp_r[CW-1:0]] <= value_r;
        end
      end
      S_NB_ACC: begin
        j_r <= j_end ? 4'd0 : j_r + 4'd1;
      end
      S_EN_MD: begin
        s_r <= spin_rd;
      end
      S_EN_AD: begin
        dsum_r <= dsum_r + DW'(prod_r);
      end
      S_EN_AL: begin
        lsum_r <= lsum_r + DW'(prod_r);
        j_r    <= j_r + 4'd1;
      end
      S_EN_FIN: begin
        if (out_free) begin
          out_kind_r <= RES_ENERGY;
          out_de_r   <= rnd_sat((DW+1)'(dsum_r));
          out_le_r   <= rnd_sat(lneg);
          out_mag_r  <= '0;
        end
      end
      S_AC_WR: begin
        j_r <= j_r + 4'd1;
      end
      S_MG_AD: begin
        ssum_r <= ssum_r + MBW'(spin_rd);
        i_r    <= i_r + SW'(1);
      end
      S_MG_SA: begin
        // saturate the sum of squares at all ones
        m_r    <= sq_sum[SQ_W] ? {SQ_W{1'b1}} : sq_sum[SQ_W-1:0];
        ssum_r <= '0;
        i_r    <= '0;
        j_r    <= j_r + 4'd1;
      end
      S_SQ_INIT: begin
        x_r    <= m_r;
        root_r <= '0;
        bit_r  <= {2'b01, {(SQ_W-2){1'b0}}};
        it_r   <= 5'd0;
      end
      S_SQRT: begin
        // one result bit per cycle
        if (x_r >= root_try) begin
          x_r    <= x_r - root_try;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        it_r  <= it_r + 5'd1;
        if (it_r == 5'd31) begin
          rem_r <= '0;
        end
      end
      S_DIV: begin
        // restoring division by the site count, one quotient bit per cycle
        if (it_r == 5'd0 && rem_r == '0 && dvd_r == dvd_r) begin
          // nothing extra; the dividend is loaded below as the square root finishes
        end
        if (rem_try >= (SW+1)'(n_sites)) begin
          rem_r <= SW'(rem_try - (SW+1)'(n_sites));
          dvd_r <= {dvd_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_try[SW-1:0];
          dvd_r <= {dvd_r[ROOT_W-2:0], 1'b0};
        end
        it_r <= it_r + 5'd1;
      end
      S_MG_OUT: begin
        if (out_free) begin
          out_kind_r <= RES_MAG;
          out_de_r   <= '0;
          out_le_r   <= '0;
          out_mag_r  <= (dvd_r > ROOT_W'(32767)) ? MAG_W'(32767) : dvd_r[MAG_W-1:0];
        end
      end
      default: begin
        j_r <= j_r;
      end
    endcase
    // Load the dividend from the root as the square root finishes.
    if (state_r == S_SQRT && it_r == 5'd31) begin
      if (x_r >= root_try) begin
        dvd_r <= ROOT_W'((root_r >> 1) + bit_r);
      end else begin
        dvd_r <= ROOT_W'(root_r >> 1);
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_delta_energy  = out_de_r;
  assign out_local_energy  = out_le_r;
  assign out_magnetization = out_mag_r;

endmodule

`default_nettype wire

### hw/rtl/nsee_checker.sv
// Port-level checker for the n-vector spin energy engine, bound to the top level.
// Depends on nsee_pkg for the result kind codes.
`default_nettype none

module nsee_port_checker
  import nsee_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic                    out_result_kind,
  input wire logic signed [OUT_W-1:0] out_delta_energy,
  input wire logic signed [OUT_W-1:0] out_local_energy,
  input wire logic [MAG_W-1:0]        out_magnetization
);

  // Reset drops any pending result word.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // A taken input word is worked on before the next input word is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // Fields that do not belong to the result kind are zero.
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result_kind == RES_ENERGY && out_magnetization == '0) ||
                   (out_result_kind == RES_MAG && out_delta_energy == '0 &&
                    out_local_energy == '0)))
    else $error("result word carries fields of the other kind");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_delta_energy) &&
      $stable(out_local_energy) && $stable(out_magnetization)))
    else $error("stalled result word changed");

endmodule

bind nvector_spin_energy_engine_top nsee_port_checker u_nsee_port_checker (.*);

`default_nettype wire
